// ===== src/bfdt_pkg.sv =====
// bfdt_pkg: shared types and constants for the brute-force distance transform
// holds field widths, op and register codes, and the square root request/response structs
// depends on nothing
`timescale 1ns / 1ps

package bfdt_pkg;

	// field widths
	localparam int COORD_W = 6;
	localparam int DIM_W   = 7;
	localparam int SQ_W    = 2 * DIM_W;
	localparam int BEST_W  = SQ_W + 1;
	localparam int DSQ_W   = 13;
	localparam int DFX_W   = 11;

	// square root: radicand is the squared distance scaled by 256
	localparam int FRAC_SH = 8;
	localparam int RAD_W   = BEST_W + FRAC_SH;
	localparam int ROOT_W  = (RAD_W + 1) / 2;
	localparam int BIT_W   = $clog2(ROOT_W);

	// saturation limits
	localparam logic [DSQ_W-1:0] DSQ_MAX = {DSQ_W{1'b1}};
	localparam logic [DFX_W-1:0] DFX_MAX = {DFX_W{1'b1}};

	// item op codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// register indexes
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd1;

	typedef struct packed {
		logic              start;
		logic [BEST_W-1:0] value;
	} sqrt_req_t;

	typedef struct packed {
		logic             done;
		logic [DFX_W-1:0] root;
	} sqrt_rsp_t;

endpackage

// ===== src/brute_force_distance_transform.sv =====
// brute_force_distance_transform: binary image store answering distance queries
//
// Input items are taken at a rising edge with start high and busy low. An item with
// op write stores pixel at (x, y) and gives no result; a write outside
// the store is dropped. An item with op query gives one result, marked by done for
// exactly one cycle, with the queried coordinates, the squared distance to the
// nearest foreground pixel of the active area, its root in 4 fraction bits and the
// no_object flag. The receiver cannot hold results off.
// A query on a foreground pixel answers without a scan. Otherwise the single read
// port of the image memory is swept one pixel a cycle over the active w by h area,
// followed by a bit-serial square root when the area holds a foreground pixel.
// The block works on one item at a time; busy stays high until the result is out.
// After reset the memory is cleared by a pass over all 2**(clog2(MAX_W)+clog2(MAX_H))
// addresses (4096 at the defaults) with busy high; configuration writes go through at
// any time. width and height reset to 64 and are written through cfg_we, cfg_idx
// and cfg_data; an index other than 0 or 1 is ignored.
// depends on bfdt_pkg, bfdt_image_mem, bfdt_sqrt
`timescale 1ns / 1ps

module brute_force_distance_transform import bfdt_pkg::*; #(
	parameter int MAX_W = 64,
	parameter int MAX_H = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 op,
	input  logic [COORD_W-1:0]   x,
	input  logic [COORD_W-1:0]   y,
	input  logic                 pixel,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_idx,
	input  logic [DIM_W-1:0]     cfg_data,
	output logic                 done,
	output logic [COORD_W-1:0]   res_x,
	output logic [COORD_W-1:0]   res_y,
	output logic [DSQ_W-1:0]     dist_sq,
	output logic [DFX_W-1:0]     dist_fixed,
	output logic                 no_object
);

	localparam int CW = $clog2(MAX_W);
	localparam int RW = $clog2(MAX_H);
	localparam int AW = CW + RW;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SELF  = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_ROOT  = 3'd5;

	logic [2:0]         state_q;
	logic [AW-1:0]      clr_q;
	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [DIM_W-1:0]   w_eff;
	logic [DIM_W-1:0]   h_eff;
	logic [DIM_W-1:0]   w_last;
	logic [DIM_W-1:0]   h_last;
	logic               accept;
	logic               in_store;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic               in_store_q;
	logic [DIM_W-1:0]   qx_q;
	logic [DIM_W-1:0]   qy_q;
	logic               vld_s1;
	logic [DIM_W-1:0]   rx_s1;
	logic [DIM_W-1:0]   ry_s1;
	logic               vld_s2;
	logic               hit_s2;
	logic [SQ_W-1:0]    dx2_s2;
	logic [SQ_W-1:0]    dy2_s2;
	logic [DIM_W-1:0]   dx;
	logic [DIM_W-1:0]   dy;
	logic [BEST_W-1:0]  sum;
	logic [BEST_W-1:0]  best_q;
	logic               found_q;
	logic               pipe_empty;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic               mem_wdata;
	logic [AW-1:0]      mem_raddr;
	logic               mem_rdata;
	sqrt_req_t          sq_req;
	sqrt_rsp_t          sq_rsp;
	logic               done_q;
	logic [COORD_W-1:0] res_x_q;
	logic [COORD_W-1:0] res_y_q;
	logic [DSQ_W-1:0]   dist_sq_q;
	logic [DFX_W-1:0]   dist_fixed_q;
	logic               no_object_q;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign in_store = (32'(x) < MAX_W) && (32'(y) < MAX_H);

	// clamp the active area to one pixel and the store size
	always_comb begin
		if (width_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (32'(width_q) > MAX_W) begin
			w_eff = DIM_W'(MAX_W);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (32'(height_q) > MAX_H) begin
			h_eff = DIM_W'(MAX_H);
		end else begin
			h_eff = height_q;
		end
	end
	assign w_last = w_eff - 1'b1;
	assign h_last = h_eff - 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(64);
			height_q <= DIM_W'(64);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_WIDTH:  width_q <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// memory port selection: clearing pass, pixel writes, self read then scan reads
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = {RW'(y), CW'(x)};
		mem_wdata = pixel;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = 1'b0;
		end else if (accept && (op == OP_WRITE) && in_store) begin
			mem_we = 1'b1;
		end
		if (state_q == ST_IDLE) begin
			mem_raddr = {RW'(y), CW'(x)};
		end else begin
			mem_raddr = {RW'(qy_q), CW'(qx_q)};
		end
	end

	bfdt_image_mem #(
		.AW(AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// scan pipeline: s1 waits for read data, s2 holds the squared offsets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			hit_s2 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN);
			vld_s2 <= vld_s1;
			hit_s2 <= vld_s1 && mem_rdata;
		end
	end

	assign dx = (rx_s1 >= DIM_W'(x_q)) ? rx_s1 - DIM_W'(x_q) : DIM_W'(x_q) - rx_s1;
	assign dy = (ry_s1 >= DIM_W'(y_q)) ? ry_s1 - DIM_W'(y_q) : DIM_W'(y_q) - ry_s1;

	always_ff @(posedge clk) begin
		rx_s1  <= qx_q;
		ry_s1  <= qy_q;
		dx2_s2 <= SQ_W'(dx) * SQ_W'(dx);
		dy2_s2 <= SQ_W'(dy) * SQ_W'(dy);
	end

	assign sum        = BEST_W'(dx2_s2) + BEST_W'(dy2_s2);
	assign pipe_empty = !vld_s1 && !vld_s2;

	// square root request once the running minimum is final
	assign sq_req.start = (state_q == ST_DRAIN) && pipe_empty && found_q;
	assign sq_req.value = best_q;

	bfdt_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_req),
		.rsp    (sq_rsp)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			qx_q    <= '0;
			qy_q    <= '0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			// running minimum over foreground hits
			if (hit_s2 && (!found_q || (sum < best_q))) begin
				found_q <= 1'b1;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && (op == OP_QUERY)) begin
						state_q <= ST_SELF;
					end
				end
				ST_SELF: begin
					if (in_store_q && mem_rdata) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						qx_q    <= '0;
						qy_q    <= '0;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (qx_q == w_last) begin
						qx_q <= '0;
						if (qy_q == h_last) begin
							state_q <= ST_DRAIN;
						end else begin
							qy_q <= qy_q + 1'b1;
						end
					end else begin
						qx_q <= qx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (pipe_empty) begin
						if (found_q) begin
							state_q <= ST_ROOT;
						end else begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_ROOT: begin
					if (sq_rsp.done) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// query item and minimum registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q        <= x;
			y_q        <= y;
			in_store_q <= in_store;
		end
		if (hit_s2 && (!found_q || (sum < best_q))) begin
			best_q <= sum;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		res_x_q <= x_q;
		res_y_q <= y_q;
		case (state_q)
			ST_ROOT: begin
				dist_sq_q    <= (best_q > BEST_W'(DSQ_MAX)) ? DSQ_MAX : best_q[DSQ_W-1:0];
				dist_fixed_q <= sq_rsp.root;
				no_object_q  <= 1'b0;
			end
			ST_DRAIN: begin
				dist_sq_q    <= '0;
				dist_fixed_q <= '0;
				no_object_q  <= 1'b1;
			end
			default: begin
				dist_sq_q    <= '0;
				dist_fixed_q <= '0;
				no_object_q  <= 1'b0;
			end
		endcase
	end

	assign done       = done_q;
	assign res_x      = res_x_q;
	assign res_y      = res_y_q;
	assign dist_sq    = dist_sq_q;
	assign dist_fixed = dist_fixed_q;
	assign no_object  = no_object_q;

	// memory is written only by the clearing pass or an accepted write item
	a_mem_we_src: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR) || (accept && (op == OP_WRITE)))
		else $error("image memory written outside clear or write item");

	// the minimum is final before the root starts
	a_root_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		sq_req.start |-> pipe_empty && (state_q == ST_DRAIN))
		else $error("square root started with scan data in flight");

	// a result strobe lasts one cycle and leaves the block idle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy ##1 !done)
		else $error("result strobe not a single cycle");

	// no object results carry zero distances
	a_no_object_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && no_object) |-> (dist_sq == '0) && (dist_fixed == '0))
		else $error("no object result with nonzero distance");

	// zero squared distance gives zero root
	a_zero_root: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (dist_sq == '0)) |-> (dist_fixed == '0))
		else $error("root nonzero for zero distance");

endmodule

// ===== src/bfdt_image_mem.sv =====
// bfdt_image_mem: one-bit image memory, one write port and one registered read port
// read data follows the address in the next cycle; contents are undefined until written
// depends on nothing
`timescale 1ns / 1ps

module bfdt_image_mem #(
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [2**AW];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== src/bfdt_sqrt.sv =====
// bfdt_sqrt: iterative integer square root of the squared distance times 256
// one result bit per cycle, result saturated to the fixed point output width
// depends on bfdt_pkg
`timescale 1ns / 1ps

module bfdt_sqrt import bfdt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  sqrt_req_t req,
	output sqrt_rsp_t rsp
);

	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W-1:0] root_q;
	logic [BIT_W-1:0]  bit_q;
	logic              run_q;
	logic              done_q;
	logic [ROOT_W-1:0] trial;
	logic [2*ROOT_W-1:0] trial_sq;

	// trial root with the current bit set
	assign trial    = root_q | (ROOT_W'(1) << bit_q);
	assign trial_sq = (2*ROOT_W)'(trial) * (2*ROOT_W)'(trial);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				bit_q <= BIT_W'(ROOT_W - 1);
			end else if (run_q) begin
				if (bit_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					bit_q <= bit_q - 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= {req.value, FRAC_SH'(0)};
			root_q <= '0;
		end else if (run_q && (trial_sq <= (2*ROOT_W)'(rad_q))) begin
			root_q <= trial;
		end
	end

	// saturated result
	assign rsp.done = done_q;
	assign rsp.root = (root_q > ROOT_W'(DFX_MAX)) ? DFX_MAX : root_q[DFX_W-1:0];

endmodule
